// ----- rtl/aca_pkg.sv -----
// ----------------------------------------------------------------------------
// aca_pkg: shared types and constants for the converter channel allocator
// Holds the channel and sensor counts, the operation and status codes, and
// the packed command and result beats.
// ----------------------------------------------------------------------------
package aca_pkg;

  // Resource counts
  localparam int SENSORS  = 8;
  localparam int CHANNELS = 8;

  // Index widths (at least one bit)
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SE_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_RESET    = 2'd0,
    OP_REQUEST  = 2'd1,
    OP_FETCH    = 2'd2,
    OP_COMPLETE = 2'd3
  } op_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_ALL_BUSY   = 3'd1,
    ST_DATA_READY = 3'd2,
    ST_RUNNING    = 3'd3,
    ST_MISMATCH   = 3'd4,
    ST_ACK        = 3'd5
  } status_t;

  // Command beat
  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         sensor_index;
    logic [2:0]         channel;
    logic signed [11:0] sample_in;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         granted_channel;
    logic signed [11:0] sample_out;
  } res_t;

endpackage

// ----- rtl/aca_pick.sv -----
// ----------------------------------------------------------------------------
// aca_pick: lowest set bit finder
// Returns whether any bit of the channel vector is set and the index of the
// lowest one (zero when none is set).
// ----------------------------------------------------------------------------
module aca_pick (
  input  logic [aca_pkg::CHANNELS-1:0] vec,
  output logic                         found,
  output logic [aca_pkg::CH_W-1:0]     idx
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = aca_pkg::CHANNELS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        found = 1'b1;
        idx   = aca_pkg::CH_W'(i);
      end
    end
  end

endmodule

// ----- rtl/adc_channel_allocator.sv -----
// ----------------------------------------------------------------------------
// adc_channel_allocator: first-free converter channel allocator
// Shares the converter channels among the sensors: grants the lowest free
// channel on request, records completions and samples, hands samples back
// on fetch, and frees every channel on a reset command.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  -------   ------------------------  ------------------------------------
//  command   start, busy, cmd (cmd_t)  beat taken when start && !busy
//  result    done, result (res_t)      one beat per command, valid while done
//
//  One command per cycle is taken while busy is low; an accepted command
//  is held in the input register and its result then loads into the result
//  register, where done marks it valid.
//  busy is registered: set during rst, cleared once rst is low; otherwise commands
//  are never held off. Reset clears the channel maps, sensor records and
//  samples. The result side cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
module adc_channel_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  aca_pkg::cmd_t  cmd,
  output logic           done,
  output aca_pkg::res_t  result
);

  localparam int CN = aca_pkg::CHANNELS;
  localparam int SN = aca_pkg::SENSORS;
  localparam int CW = aca_pkg::CH_W;
  localparam int SW = aca_pkg::SE_W;

  // Channel and sensor state
  logic [CN-1:0]        busy_map, busy_map_next;
  logic [CN-1:0]        running_map, running_map_next;
  logic [CN-1:0]        sensor_channel [SN];
  logic signed [11:0]   sample_store [CN];

  // Input register
  logic                 stg_vld;
  aca_pkg::cmd_t        stg;

  // Decode of the held command
  aca_pkg::op_t         op;
  logic                 sensor_ok, chan_ok;
  logic [SW-1:0]        sens;
  logic [CW-1:0]        chan;
  logic [CN-1:0]        rec;
  logic                 free_found, rec_found;
  logic [CW-1:0]        free_idx, rec_idx;
  logic                 rec_wr, smp_wr;
  aca_pkg::res_t        res_next;

  // Accept gate: held busy by reset, registered
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else begin
      stg_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stg <= cmd;
    end
  end

  assign op        = aca_pkg::op_t'(stg.operation);
  assign sensor_ok = (32'(stg.sensor_index) < SN);
  assign chan_ok   = (32'(stg.channel) < CN);
  assign sens      = SW'(stg.sensor_index);
  assign chan      = CW'(stg.channel);
  assign rec       = sensor_channel[sens];

  // Lowest free channel for requests, recorded channel for fetches
  aca_pick u_free (
    .vec   (~busy_map),
    .found (free_found),
    .idx   (free_idx)
  );

  aca_pick u_rec (
    .vec   (rec),
    .found (rec_found),
    .idx   (rec_idx)
  );

  // Operation logic
  always_comb begin
    busy_map_next    = busy_map;
    running_map_next = running_map;
    rec_wr           = 1'b0;
    smp_wr           = 1'b0;
    res_next         = '{status: aca_pkg::ST_ACK, granted_channel: '0, sample_out: '0};
    unique case (op)
      aca_pkg::OP_RESET: begin
        busy_map_next    = '0;
        running_map_next = '0;
      end
      aca_pkg::OP_REQUEST: begin
        if (!sensor_ok) begin
          res_next.status = aca_pkg::ST_MISMATCH;
        end else if (!free_found) begin
          res_next.status = aca_pkg::ST_ALL_BUSY;
        end else begin
          busy_map_next[free_idx]    = 1'b1;
          running_map_next[free_idx] = 1'b1;
          rec_wr                     = 1'b1;
          res_next.status            = aca_pkg::ST_GRANTED;
          res_next.granted_channel   = 3'(free_idx);
        end
      end
      aca_pkg::OP_FETCH: begin
        if (!sensor_ok || !rec_found) begin
          res_next.status = aca_pkg::ST_MISMATCH;
        end else if (running_map[rec_idx]) begin
          res_next.status          = aca_pkg::ST_RUNNING;
          res_next.granted_channel = 3'(rec_idx);
        end else begin
          busy_map_next[rec_idx]   = 1'b0;
          res_next.status          = aca_pkg::ST_DATA_READY;
          res_next.granted_channel = 3'(rec_idx);
          res_next.sample_out      = sample_store[rec_idx];
        end
      end
      aca_pkg::OP_COMPLETE: begin
        if (chan_ok) begin
          running_map_next[chan] = 1'b0;
          smp_wr                 = 1'b1;
        end
      end
      default: begin
        res_next.status = aca_pkg::ST_ACK;
      end
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_map    <= '0;
      running_map <= '0;
      for (int i = 0; i < SN; i++) begin
        sensor_channel[i] <= '0;
      end
      for (int i = 0; i < CN; i++) begin
        sample_store[i] <= '0;
      end
    end else if (stg_vld) begin
      busy_map    <= busy_map_next;
      running_map <= running_map_next;
      if (rec_wr) begin
        sensor_channel[sens] <= CN'(1) << free_idx;
      end
      if (smp_wr) begin
        sample_store[chan] <= stg.sample_in;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld) begin
      result <= res_next;
    end
  end

  // A channel can only be converting while it is allocated
  a_run_in_busy: assert property (@(posedge clk) disable iff (rst)
    (running_map & ~busy_map) == '0)
    else $error("running channel not marked busy");

  // Every accepted beat yields a result after the input and result registers
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted command produced no result");

  // A granted channel is marked busy when the grant is reported
  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == aca_pkg::ST_GRANTED) |-> busy_map[CW'(result.granted_channel)])
    else $error("granted channel not busy");

  // Sample data only travels with a data-ready status
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != aca_pkg::ST_DATA_READY) |-> (result.sample_out == '0))
    else $error("sample returned without data ready");

endmodule
